/* hdl/md5_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, micro-op codes and MD5 round tables for the streaming hash.
// ----------------------------------------------------------------------------
package md5_pkg;

    // datapath operation of one microcode step
    typedef enum logic [2:0] {
        U_WAIT    = 3'd0,
        U_PUT80   = 3'd1,
        U_FILL    = 3'd2,
        U_COMP    = 3'd3,
        U_FOLD    = 3'd4,
        U_SETLEN  = 3'd5,
        U_EMIT_LO = 3'd6,
        U_EMIT_HI = 3'd7
    } t_uop;

    // condition that keeps the step counter where it is
    typedef enum logic [2:0] {
        H_NONE = 3'd0,
        H_WAIT = 3'd1,
        H_FILL = 3'd2,
        H_COMP = 3'd3,
        H_OUT  = 3'd4
    } t_hold;

    // condition for a jump to the target step
    typedef enum logic [2:0] {
        J_NONE     = 3'd0,
        J_ALWAYS   = 3'd1,
        J_NOT_FULL = 3'd2,
        J_NOT_END  = 3'd3,
        J_PTR_LAST = 3'd4,
        J_LENBLK   = 3'd5
    } t_jump;

    // microprogram addresses
    typedef enum logic [3:0] {
        S_WAIT     = 4'd0,
        S_COMP_A   = 4'd1,
        S_FOLD_A   = 4'd2,
        S_PUT80    = 4'd3,
        S_FILL     = 4'd4,
        S_COMP_B   = 4'd5,
        S_FOLD_B   = 4'd6,
        S_SETLEN   = 4'd7,
        S_EMIT_LO  = 4'd8,
        S_EMIT_HI  = 4'd9
    } t_upc;

    typedef struct packed {
        t_uop  op;
        t_hold hold;
        t_jump jump;
        t_upc  target;
    } t_uword;

    // status flags the sequencer branches on
    typedef struct packed {
        logic acc;
        logic acc_full;
        logic acc_end;
        logic msg_end;
        logic ptr_last;
        logic len_blk;
        logic cmp_done;
        logic out_busy;
    } t_ucond;

    // commands to the compression unit
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_byte;
        logic       start;
        logic       fold;
        logic       restart;
    } t_cmp_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cmp_sts;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // message word used by round i
    function automatic logic [3:0] md5_msg_idx(input logic [5:0] i);
        logic [3:0] lo;
        begin
            lo = i[3:0];
            case (i[5:4])
                2'd0:    md5_msg_idx = lo;
                2'd1:    md5_msg_idx = 4'((lo << 2) + lo + 4'd1);
                2'd2:    md5_msg_idx = 4'((lo << 1) + lo + 4'd5);
                default: md5_msg_idx = 4'((lo << 3) - lo);
            endcase
        end
    endfunction

    // left rotate amount of round i
    function automatic logic [4:0] md5_rot(input logic [5:0] i);
        case ({i[5:4], i[1:0]})
            4'd0:    md5_rot = 5'd7;
            4'd1:    md5_rot = 5'd12;
            4'd2:    md5_rot = 5'd17;
            4'd3:    md5_rot = 5'd22;
            4'd4:    md5_rot = 5'd5;
            4'd5:    md5_rot = 5'd9;
            4'd6:    md5_rot = 5'd14;
            4'd7:    md5_rot = 5'd20;
            4'd8:    md5_rot = 5'd4;
            4'd9:    md5_rot = 5'd11;
            4'd10:   md5_rot = 5'd16;
            4'd11:   md5_rot = 5'd23;
            4'd12:   md5_rot = 5'd6;
            4'd13:   md5_rot = 5'd10;
            4'd14:   md5_rot = 5'd15;
            default: md5_rot = 5'd21;
        endcase
    endfunction

    // additive constant of round i
    function automatic logic [31:0] md5_kconst(input logic [5:0] i);
        case (i)
            6'd0:  md5_kconst = 32'hd76aa478;
            6'd1:  md5_kconst = 32'he8c7b756;
            6'd2:  md5_kconst = 32'h242070db;
            6'd3:  md5_kconst = 32'hc1bdceee;
            6'd4:  md5_kconst = 32'hf57c0faf;
            6'd5:  md5_kconst = 32'h4787c62a;
            6'd6:  md5_kconst = 32'ha8304613;
            6'd7:  md5_kconst = 32'hfd469501;
            6'd8:  md5_kconst = 32'h698098d8;
            6'd9:  md5_kconst = 32'h8b44f7af;
            6'd10: md5_kconst = 32'hffff5bb1;
            6'd11: md5_kconst = 32'h895cd7be;
            6'd12: md5_kconst = 32'h6b901122;
            6'd13: md5_kconst = 32'hfd987193;
            6'd14: md5_kconst = 32'ha679438e;
            6'd15: md5_kconst = 32'h49b40821;
            6'd16: md5_kconst = 32'hf61e2562;
            6'd17: md5_kconst = 32'hc040b340;
            6'd18: md5_kconst = 32'h265e5a51;
            6'd19: md5_kconst = 32'he9b6c7aa;
            6'd20: md5_kconst = 32'hd62f105d;
            6'd21: md5_kconst = 32'h02441453;
            6'd22: md5_kconst = 32'hd8a1e681;
            6'd23: md5_kconst = 32'he7d3fbc8;
            6'd24: md5_kconst = 32'h21e1cde6;
            6'd25: md5_kconst = 32'hc33707d6;
            6'd26: md5_kconst = 32'hf4d50d87;
            6'd27: md5_kconst = 32'h455a14ed;
            6'd28: md5_kconst = 32'ha9e3e905;
            6'd29: md5_kconst = 32'hfcefa3f8;
            6'd30: md5_kconst = 32'h676f02d9;
            6'd31: md5_kconst = 32'h8d2a4c8a;
            6'd32: md5_kconst = 32'hfffa3942;
            6'd33: md5_kconst = 32'h8771f681;
            6'd34: md5_kconst = 32'h6d9d6122;
            6'd35: md5_kconst = 32'hfde5380c;
            6'd36: md5_kconst = 32'ha4beea44;
            6'd37: md5_kconst = 32'h4bdecfa9;
            6'd38: md5_kconst = 32'hf6bb4b60;
            6'd39: md5_kconst = 32'hbebfbc70;
            6'd40: md5_kconst = 32'h289b7ec6;
            6'd41: md5_kconst = 32'heaa127fa;
            6'd42: md5_kconst = 32'hd4ef3085;
            6'd43: md5_kconst = 32'h04881d05;
            6'd44: md5_kconst = 32'hd9d4d039;
            6'd45: md5_kconst = 32'he6db99e5;
            6'd46: md5_kconst = 32'h1fa27cf8;
            6'd47: md5_kconst = 32'hc4ac5665;
            6'd48: md5_kconst = 32'hf4292244;
            6'd49: md5_kconst = 32'h432aff97;
            6'd50: md5_kconst = 32'hab9423a7;
            6'd51: md5_kconst = 32'hfc93a039;
            6'd52: md5_kconst = 32'h655b59c3;
            6'd53: md5_kconst = 32'h8f0ccc92;
            6'd54: md5_kconst = 32'hffeff47d;
            6'd55: md5_kconst = 32'h85845dd1;
            6'd56: md5_kconst = 32'h6fa87e4f;
            6'd57: md5_kconst = 32'hfe2ce6e0;
            6'd58: md5_kconst = 32'ha3014314;
            6'd59: md5_kconst = 32'h4e0811a1;
            6'd60: md5_kconst = 32'hf7537e82;
            6'd61: md5_kconst = 32'hbd3af235;
            6'd62: md5_kconst = 32'h2ad7d2bb;
            default: md5_kconst = 32'heb86d391;
        endcase
    endfunction

    // 32-bit left rotate
    function automatic logic [31:0] md5_rotl(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        begin
            dbl = {v, v} << s;
            md5_rotl = dbl[63:32];
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/md5_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5_stream_if
// Request channels of the hash core: message bytes in, digest halves out.
// ----------------------------------------------------------------------------
interface md5_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output msg_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input msg_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface md5_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_half;
    logic        half_index;
    logic        last_half;

    modport source (output valid, output digest_half, output half_index,
                    output last_half, input ready);
    modport sink   (input valid, input digest_half, input half_index,
                    input last_half, output ready);
endinterface
`default_nettype wire

/* hdl/md5_useq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5_useq
// Microcode sequencer: step counter, control ROM, hold and jump conditions.
// ----------------------------------------------------------------------------
module md5_useq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire md5_pkg::t_ucond i_cond,
    output md5_pkg::t_uword      o_uword
);
    import md5_pkg::*;

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uw;
    logic   hold_true;
    logic   jump_true;

    // control ROM
    always_comb begin
        case (r_pc)
            S_WAIT:    uw = '{U_WAIT,    H_WAIT, J_NOT_FULL, S_PUT80};
            S_COMP_A:  uw = '{U_COMP,    H_COMP, J_NONE,     S_WAIT};
            S_FOLD_A:  uw = '{U_FOLD,    H_NONE, J_NOT_END,  S_WAIT};
            S_PUT80:   uw = '{U_PUT80,   H_NONE, J_PTR_LAST, S_COMP_B};
            S_FILL:    uw = '{U_FILL,    H_FILL, J_NONE,     S_WAIT};
            S_COMP_B:  uw = '{U_COMP,    H_COMP, J_NONE,     S_WAIT};
            S_FOLD_B:  uw = '{U_FOLD,    H_NONE, J_LENBLK,   S_EMIT_LO};
            S_SETLEN:  uw = '{U_SETLEN,  H_NONE, J_ALWAYS,   S_FILL};
            S_EMIT_LO: uw = '{U_EMIT_LO, H_OUT,  J_NONE,     S_WAIT};
            S_EMIT_HI: uw = '{U_EMIT_HI, H_OUT,  J_ALWAYS,   S_WAIT};
            default:   uw = '{U_WAIT,    H_NONE, J_ALWAYS,   S_WAIT};
        endcase
    end

    assign o_uword = uw;

    // hold and jump decode
    always_comb begin
        case (uw.hold)
            H_WAIT:  hold_true = !(i_cond.acc && (i_cond.acc_full || i_cond.acc_end));
            H_FILL:  hold_true = !i_cond.ptr_last;
            H_COMP:  hold_true = !i_cond.cmp_done;
            H_OUT:   hold_true = i_cond.out_busy;
            default: hold_true = 1'b0;
        endcase
        case (uw.jump)
            J_ALWAYS:   jump_true = 1'b1;
            J_NOT_FULL: jump_true = !i_cond.acc_full;
            J_NOT_END:  jump_true = !i_cond.msg_end;
            J_PTR_LAST: jump_true = i_cond.ptr_last;
            J_LENBLK:   jump_true = i_cond.len_blk;
            default:    jump_true = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (hold_true) begin
            n_pc = r_pc;
        end else if (jump_true) begin
            n_pc = uw.target;
        end else begin
            n_pc = t_upc'(4'(r_pc) + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

/* hdl/md5_compress.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5_compress
// Block buffer, chaining words and one MD5 round per cycle.
// ----------------------------------------------------------------------------
module md5_compress (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire md5_pkg::t_cmp_ctl  i_ctl,
    output md5_pkg::t_cmp_sts       o_sts,
    output logic [127:0]            o_digest
);
    import md5_pkg::*;

    logic [31:0] r_buf [16];
    logic [31:0] r_w;
    logic [31:0] r_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_i;
    logic        r_busy;

    logic [3:0]  rd_addr;
    logic        done;
    logic [31:0] f;
    logic [31:0] sum;
    logic [31:0] n_b;

    assign done = r_busy && (r_i == 6'd63);
    assign o_sts = '{busy: r_busy, done: done};
    assign o_digest = {r_chain[3], r_chain[2], r_chain[1], r_chain[0]};

    // word for the next round, read in the cycle before that round
    assign rd_addr = r_busy ? md5_msg_idx(6'(r_i + 6'd1)) : md5_msg_idx(6'd0);

    // block buffer: byte writes, registered word read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_buf[i_ctl.wr_addr[5:2]][{i_ctl.wr_addr[1:0], 3'b000} +: 8] <= i_ctl.wr_byte;
        end
        r_w <= r_buf[rd_addr];
    end

    // round function
    always_comb begin
        case (r_i[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + md5_kconst(r_i) + r_w;
        n_b = r_b + md5_rotl(sum, md5_rot(r_i));
    end

    // round registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (r_busy) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= n_b;
        end
    end

    // round counter and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_i        <= '0;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
        end else begin
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= 6'(r_i + 6'd1);
                if (done) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_ctl.restart) begin
                r_chain[0] <= IV_A;
                r_chain[1] <= IV_B;
                r_chain[2] <= IV_C;
                r_chain[3] <= IV_D;
            end else if (i_ctl.fold) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
        end
    end

    // no new block while rounds run, no buffer write under a running block
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy) else $error("compression restarted while busy");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en |-> !r_busy) else $error("buffer written during compression");
    a_fold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.fold |-> !r_busy && $past(done)) else $error("fold before rounds finished");

endmodule
`default_nettype wire

/* hdl/md5_stream_hash_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md5_stream_hash_core
// Streaming MD5 digest of a byte message, microcoded control.
// ----------------------------------------------------------------------------
// Usage:
//   i_msg carries one request per message byte (byte_present) with
//   end_of_message on the final request; an end request without a byte
//   closes the message as it stands, so a lone one hashes the empty message.
//   o_dig returns two requests per message: digest bytes 0..7 (half_index 0)
//   then bytes 8..15 (half_index 1, last_half 1), first byte in bits [7:0].
// Throughput: one byte per cycle while a block fills. The 64th byte of a
//   block holds i_msg off while the block is compressed: a start step,
//   the rounds of the single round unit, then a fold step.
// Padding: from the end request the padding is written one byte a cycle
//   into the 64-byte buffer; one padding block, or two when the mark
//   lands at byte 56 or later, is compressed and folded before the first
//   half is loaded (a block the end byte fills is compressed first). The
//   second half follows in the next cycle when the first is taken at once.
// Reset: chaining words go to the MD5 initial values, the byte count to zero,
//   the sequencer to the byte wait step; the buffer itself is not cleared.
// Stall: a digest half sits in the output register until taken; i_msg is
//   accepted again as soon as the second half is loaded.
// ----------------------------------------------------------------------------
module md5_stream_hash_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    md5_msg_if.sink     i_msg,
    md5_dig_if.source   o_dig
);
    import md5_pkg::*;

    t_uword   uw;
    t_ucond   cond;
    t_cmp_ctl ctl;
    t_cmp_sts sts;
    logic [127:0] digest;

    logic [5:0]  r_ptr,    n_ptr;
    logic [63:0] r_cnt,    n_cnt;
    logic        r_end,    n_end;
    logic        r_lenblk, n_lenblk;
    logic        r_ovalid, n_ovalid;
    logic [63:0] r_odata,  n_odata;
    logic        r_oidx,   n_oidx;
    logic        r_olast,  n_olast;

    logic        acc;
    logic        out_busy;
    logic [63:0] len_bits;
    logic [7:0]  pad_byte;

    md5_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_uword (uw)
    );

    md5_compress u_comp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_digest (digest)
    );

    // handshakes
    assign i_msg.ready       = (uw.op == U_WAIT);
    assign acc               = i_msg.valid && i_msg.ready;
    assign out_busy          = r_ovalid && !o_dig.ready;
    assign o_dig.valid       = r_ovalid;
    assign o_dig.digest_half = r_odata;
    assign o_dig.half_index  = r_oidx;
    assign o_dig.last_half   = r_olast;

    // padding byte: zero, or the bit length in the last eight bytes
    assign len_bits = {r_cnt[60:0], 3'b000};
    assign pad_byte = (r_lenblk && (r_ptr[5:3] == 3'b111))
                    ? len_bits[{r_ptr[2:0], 3'b000} +: 8] : 8'h00;

    // sequencer conditions
    always_comb begin
        cond.acc      = acc;
        cond.acc_full = acc && i_msg.byte_present && (r_ptr == 6'd63);
        cond.acc_end  = acc && i_msg.end_of_message;
        cond.msg_end  = r_end;
        cond.ptr_last = (r_ptr == 6'd63);
        cond.len_blk  = r_lenblk;
        cond.cmp_done = sts.done;
        cond.out_busy = out_busy;
    end

    // datapath decode of the current control word
    always_comb begin
        ctl      = '{wr_en: 1'b0, wr_addr: r_ptr, wr_byte: pad_byte,
                     start: 1'b0, fold: 1'b0, restart: 1'b0};
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_end    = r_end;
        n_lenblk = r_lenblk;
        n_ovalid = r_ovalid && !o_dig.ready;
        n_odata  = r_odata;
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        case (uw.op)
            U_WAIT: begin
                if (acc) begin
                    n_end = i_msg.end_of_message;
                    if (i_msg.byte_present) begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_byte = i_msg.msg_byte;
                        n_ptr       = 6'(r_ptr + 6'd1);
                        n_cnt       = r_cnt + 64'd1;
                    end
                end
            end
            U_PUT80: begin
                ctl.wr_en   = 1'b1;
                ctl.wr_byte = PAD_MARK;
                n_ptr       = 6'(r_ptr + 6'd1);
                n_lenblk    = (r_ptr[5:3] != 3'b111);
            end
            U_FILL: begin
                ctl.wr_en = 1'b1;
                n_ptr     = 6'(r_ptr + 6'd1);
            end
            U_COMP: begin
                ctl.start = !sts.busy;
            end
            U_FOLD: begin
                ctl.fold = 1'b1;
            end
            U_SETLEN: begin
                n_lenblk = 1'b1;
            end
            U_EMIT_LO: begin
                if (!out_busy) begin
                    n_ovalid = 1'b1;
                    n_odata  = digest[63:0];
                    n_oidx   = 1'b0;
                    n_olast  = 1'b0;
                end
            end
            U_EMIT_HI: begin
                if (!out_busy) begin
                    n_ovalid    = 1'b1;
                    n_odata     = digest[127:64];
                    n_oidx      = 1'b1;
                    n_olast     = 1'b1;
                    ctl.restart = 1'b1;
                    n_ptr       = '0;
                    n_cnt       = '0;
                end
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_cnt    <= '0;
            r_end    <= 1'b0;
            r_lenblk <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_ptr    <= n_ptr;
            r_cnt    <= n_cnt;
            r_end    <= n_end;
            r_lenblk <= n_lenblk;
            r_ovalid <= n_ovalid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

    // write pointer follows the byte count between messages bytes
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == U_WAIT) |-> (r_ptr == r_cnt[5:0])) else $error("write pointer off count");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_msg.ready |-> !sts.busy) else $error("input taken during compression");
    a_hi_after_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.op == U_EMIT_HI) |-> r_ovalid && !r_oidx || r_oidx && r_olast)
        else $error("second half without first");

endmodule
`default_nettype wire
